// File: design/pidsc_pkg.sv
// ----------------------------------------------------------------------------
// pidsc_pkg
// Shared widths, limits, register indexes and types of the speed PID block.
// ----------------------------------------------------------------------------
`default_nettype none

package pidsc_pkg;

  // field and internal widths
  localparam int TGT_W    = 15;  // target speed and measured speed
  localparam int GAIN_W   = 16;  // signed Q8.8 gains
  localparam int ERR_W    = 17;  // target minus measured
  localparam int DIFF_W   = 18;  // change in error
  localparam int ESUM_W   = 14;  // clamped integral
  localparam int ISUM_W   = 18;  // integral before clamping
  localparam int PPROD_W  = GAIN_W + ERR_W;
  localparam int IPROD_W  = GAIN_W + ESUM_W;
  localparam int DPROD_W  = GAIN_W + DIFF_W;
  localparam int ACC_W    = 36;  // sum of the three products plus headroom
  localparam int DRIVE_W  = 14;
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 16;

  // limits and scaling
  localparam int INTEGRAL_LIMIT = 5000;
  localparam int OUTPUT_LIMIT   = 7100;
  localparam int GAIN_FRAC_BITS = 8;

  // reset values of the registers
  localparam logic signed [TGT_W-1:0]  TARGET_RST = '0;
  localparam logic signed [GAIN_W-1:0] GAIN_P_RST = 16'sd3840;
  localparam logic signed [GAIN_W-1:0] GAIN_I_RST = 16'sd205;
  localparam logic signed [GAIN_W-1:0] GAIN_D_RST = 16'sd512;

  // register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TARGET_SPEED = 8'd0,
    REG_GAIN_P       = 8'd1,
    REG_GAIN_I       = 8'd2,
    REG_GAIN_D       = 8'd3
  } cfg_reg_t;

  // current register contents
  typedef struct packed {
    logic signed [TGT_W-1:0]  target_speed;
    logic signed [GAIN_W-1:0] gain_p;
    logic signed [GAIN_W-1:0] gain_i;
    logic signed [GAIN_W-1:0] gain_d;
  } pid_cfg_t;

  // loop state carried from one sample to the next
  typedef struct packed {
    logic signed [ESUM_W-1:0] error_sum;
    logic signed [ERR_W-1:0]  prev_error;
  } pid_state_t;

endpackage

`default_nettype wire

// File: design/pidsc_cfg_regs.sv
// ----------------------------------------------------------------------------
// pidsc_cfg_regs
// Configuration registers: target speed and the three loop gains.
// ----------------------------------------------------------------------------
`default_nettype none

module pidsc_cfg_regs (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             wr_en,
  input  wire logic [pidsc_pkg::CFG_IDX_W-1:0]  wr_index,
  input  wire logic [pidsc_pkg::CFG_DATA_W-1:0] wr_data,
  output pidsc_pkg::pid_cfg_t                   cfg
);
  import pidsc_pkg::*;

  pid_cfg_t cfg_r;
  pid_cfg_t cfg_nxt;

  // decode a register write, unknown indexes are dropped
  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (cfg_reg_t'(wr_index))
        REG_TARGET_SPEED: cfg_nxt.target_speed = wr_data[TGT_W-1:0];
        REG_GAIN_P:       cfg_nxt.gain_p       = wr_data[GAIN_W-1:0];
        REG_GAIN_I:       cfg_nxt.gain_i       = wr_data[GAIN_W-1:0];
        REG_GAIN_D:       cfg_nxt.gain_d       = wr_data[GAIN_W-1:0];
        default:          cfg_nxt              = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.target_speed <= TARGET_RST;
      cfg_r.gain_p       <= GAIN_P_RST;
      cfg_r.gain_i       <= GAIN_I_RST;
      cfg_r.gain_d       <= GAIN_D_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

`default_nettype wire

// File: design/pidsc_datapath.sv
// ----------------------------------------------------------------------------
// pidsc_datapath
// One PID pass: error, clamped integral, three products, scaling, saturation.
// ----------------------------------------------------------------------------
`default_nettype none

module pidsc_datapath (
  input  wire logic signed [pidsc_pkg::TGT_W-1:0]   meas,
  input  wire pidsc_pkg::pid_cfg_t                  cfg,
  input  wire pidsc_pkg::pid_state_t                state,
  output pidsc_pkg::pid_state_t                     state_nxt,
  output logic signed [pidsc_pkg::DRIVE_W-1:0]      drive
);
  import pidsc_pkg::*;

  logic signed [ERR_W-1:0]   err;
  logic signed [ISUM_W-1:0]  isum;
  logic signed [ESUM_W-1:0]  esum;
  logic signed [DIFF_W-1:0]  diff;
  logic signed [PPROD_W-1:0] p_prod;
  logic signed [IPROD_W-1:0] i_prod;
  logic signed [DPROD_W-1:0] d_prod;
  logic signed [ACC_W-1:0]   acc;
  logic signed [ACC_W-1:0]   acc_adj;
  logic signed [ACC_W-1:0]   scaled;

  // error and its change since the last sample
  assign err  = ERR_W'(cfg.target_speed) - ERR_W'(meas);
  assign diff = DIFF_W'(err) - DIFF_W'(state.prev_error);

  // integral at full width, then clamp
  assign isum = ISUM_W'(state.error_sum) + ISUM_W'(err);

  always_comb begin
    if (isum > ISUM_W'(INTEGRAL_LIMIT)) begin
      esum = ESUM_W'(INTEGRAL_LIMIT);
    end else if (isum < -ISUM_W'(INTEGRAL_LIMIT)) begin
      esum = -ESUM_W'(INTEGRAL_LIMIT);
    end else begin
      esum = isum[ESUM_W-1:0];
    end
  end

  // the three gain products
  assign p_prod = cfg.gain_p * err;
  assign i_prod = cfg.gain_i * esum;
  assign d_prod = cfg.gain_d * diff;

  assign acc = ACC_W'(p_prod) + ACC_W'(i_prod) + ACC_W'(d_prod);

  // drop fraction bits, truncating toward zero
  assign acc_adj = acc[ACC_W-1] ? acc + ACC_W'((1 << GAIN_FRAC_BITS) - 1) : acc;
  assign scaled  = acc_adj >>> GAIN_FRAC_BITS;

  // output saturation
  always_comb begin
    if (scaled > ACC_W'(OUTPUT_LIMIT)) begin
      drive = DRIVE_W'(OUTPUT_LIMIT);
    end else if (scaled < -ACC_W'(OUTPUT_LIMIT)) begin
      drive = -DRIVE_W'(OUTPUT_LIMIT);
    end else begin
      drive = scaled[DRIVE_W-1:0];
    end
  end

  assign state_nxt = '{error_sum: esum, prev_error: err};

endmodule

`default_nettype wire

// File: design/pid_speed_controller_clamped.sv
// ----------------------------------------------------------------------------
// pid_speed_controller_clamped
// Speed PID loop with integral clamp and saturated drive output.
// An accepted sample moves from the input register to the output register.
// Throughput: one sample per cycle while the output is not stalled; an input
// register feeds one registered pass through the error, product and clamp logic
// into the output register. Reset: synchronous active-low; clears valids, the
// integral and the stored error, and loads the default target and gains.
// ----------------------------------------------------------------------------
`default_nettype none

module pid_speed_controller_clamped (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  // sample input
  input  wire logic                                in_valid,
  output logic                                     in_stall,
  input  wire logic signed [pidsc_pkg::TGT_W-1:0]  in_measured_speed,
  // drive output
  output logic                                     out_valid,
  input  wire logic                                out_stall,
  output logic signed [pidsc_pkg::DRIVE_W-1:0]     out_drive,
  // configuration writes
  input  wire logic                                cfg_valid,
  output logic                                     cfg_ready,
  input  wire logic [pidsc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [pidsc_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import pidsc_pkg::*;

  pid_cfg_t   cfg;
  pid_state_t state_r;
  pid_state_t state_nxt;

  logic                        s1_valid_r;
  logic signed [TGT_W-1:0]     s1_meas_r;
  logic                        out_valid_r;
  logic signed [DRIVE_W-1:0]   out_drive_r;
  logic signed [DRIVE_W-1:0]   drive_nxt;
  logic                        out_adv;
  logic                        s1_adv;

  // registers always take writes
  assign cfg_ready = 1'b1;

  pidsc_cfg_regs u_cfg_regs (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  // pipeline advance
  assign out_adv  = !out_valid_r || !out_stall;
  assign s1_adv   = !s1_valid_r || out_adv;
  assign in_stall = !s1_adv;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (s1_adv) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && in_valid) begin
      s1_meas_r <= in_measured_speed;
    end
  end

  pidsc_datapath u_datapath (
    .meas      (s1_meas_r),
    .cfg       (cfg),
    .state     (state_r),
    .state_nxt (state_nxt),
    .drive     (drive_nxt)
  );

  // loop state and output register move together
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= '0;
      out_valid_r <= 1'b0;
    end else if (out_adv) begin
      out_valid_r <= s1_valid_r;
      if (s1_valid_r) begin
        state_r <= state_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_adv && s1_valid_r) begin
      out_drive_r <= drive_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_drive = out_drive_r;

`ifndef ASSERT_OFF
  // an accepted sample lands in the input register
  a_in_capture: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> s1_valid_r)
    else $error("accepted sample not captured");

  // stall only when both stages are full and the output is held
  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> s1_valid_r && out_valid_r && out_stall)
    else $error("input stalled with room in the pipeline");

  // integral stays inside its clamp
  a_integral_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r.error_sum <= ESUM_W'(INTEGRAL_LIMIT)) &&
    (state_r.error_sum >= -ESUM_W'(INTEGRAL_LIMIT)))
    else $error("integral outside clamp");

  // delivered drive stays inside saturation
  a_drive_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_drive <= DRIVE_W'(OUTPUT_LIMIT)) &&
                  (out_drive >= -DRIVE_W'(OUTPUT_LIMIT)))
    else $error("drive outside saturation");
`endif

endmodule

`default_nettype wire
